FILE: hdl/skht_pkg.sv
// ----------------------------------------------------------------------------
// skht_pkg: shared types for the string keyed hash table
// Beat payloads, op codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package skht_pkg;

  localparam logic [19:0] HASH_MULT  = 20'd1000003;
  localparam int          SEED_SHIFT = 7;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_EXISTS = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] data_in;
  } item_t;

  typedef struct packed {
    logic [31:0] entry_data;
    logic        present;
    logic [9:0]  slot_index;
    logic        key_too_long;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_PREP,
    ST_DIV,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic prep;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic last;
    logic overflow;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/skht_ram.sv
// ----------------------------------------------------------------------------
// skht_ram: generic simple dual port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/skht_ctrl.sv
// ----------------------------------------------------------------------------
// skht_ctrl: sequencer for the hash table
// Steps clear sweep, per-byte multiply, remainder loop and table update.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_ctrl
  import skht_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (status.clr_done) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_ADD;
      ST_ADD:    state_next = status.last ? ST_PREP : ST_IDLE;
      ST_PREP:   state_next = status.overflow ? ST_IDLE : ST_DIV;
      ST_DIV:    if (status.div_done) state_next = ST_READ;
      ST_READ:   state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR:  cmd.clr_step = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_MUL_LO: cmd.mul_lo   = 1'b1;
      ST_MUL_HI: cmd.mul_hi   = 1'b1;
      ST_ADD:    cmd.add      = 1'b1;
      ST_PREP:   cmd.prep     = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_READ:   cmd          = '0;
      ST_WRITE:  cmd.commit   = 1'b1;
      default:   cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/skht_dp.sv
// ----------------------------------------------------------------------------
// skht_dp: hash table datapath
// Hash accumulator, shared 32x20 multiplier, restoring remainder, slot RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_dp
  import skht_pkg::*;
#(
  parameter int TABLE_DEPTH  = 1024,
  parameter int MAX_KEY_LEN  = 4096,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire item_t       item,
  input  wire cmd_t        cmd,
  output status_t          status,
  output result_t          result,
  output logic             done
);

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int LW      = $clog2(MAX_KEY_LEN + 2);
  localparam int STORE_W = (HANDLE_WIDTH < 32) ? HANDLE_WIDTH : 32;

  logic [10:0]        slot_count;
  op_t                op_r;
  logic [7:0]         byte_r;
  logic               last_r;
  logic [STORE_W-1:0] data_r;
  logic [63:0]        hash;
  logic [51:0]        prod_lo;
  logic [31:0]        prod_hi;
  logic [LW-1:0]      key_length;
  logic               first_pending;
  logic               overflow_flag;
  logic [63:0]        dividend;
  logic [10:0]        divisor;
  logic [10:0]        rem;
  logic [5:0]         div_cnt;
  logic [AW-1:0]      clr_cnt;

  logic [31:0]        mul_a;
  logic [51:0]        mul_p;
  logic [63:0]        hash_sum;
  logic [63:0]        hash_x;
  logic [63:0]        hash_fix;
  logic [10:0]        eff;
  logic [11:0]        trial;
  logic               trial_ge;
  logic [10:0]        rem_next;
  logic [AW-1:0]      slot;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0] ram_rdata;

  // shared multiplier: low half first, then high half (only its low word matters)
  assign mul_a    = cmd.mul_hi ? hash[63:32] : hash[31:0];
  assign mul_p    = {20'd0, mul_a} * {32'd0, HASH_MULT};
  assign hash_sum = (64'(prod_lo) + {prod_hi, 32'd0}) ^ 64'(byte_r);

  assign hash_x   = hash ^ 64'(key_length);
  assign hash_fix = (&hash_x) ? {{63{1'b1}}, 1'b0} : hash_x;

  always_comb begin
    if (slot_count == 11'd0) begin
      eff = 11'd1;
    end else if (32'(slot_count) > TABLE_DEPTH) begin
      eff = 11'(TABLE_DEPTH);
    end else begin
      eff = slot_count;
    end
  end

  assign trial    = {rem, dividend[63]};
  assign trial_ge = trial >= {1'b0, divisor};
  assign rem_next = trial_ge ? 11'(trial - {1'b0, divisor}) : trial[10:0];
  assign slot     = AW'(rem);

  assign status.clr_done = clr_cnt == AW'(TABLE_DEPTH - 1);
  assign status.div_done = div_cnt == 6'd63;
  assign status.last     = last_r;
  assign status.overflow = overflow_flag;

  always_comb begin
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.commit && (op_r == OP_INSERT || op_r == OP_REMOVE);
      ram_waddr = slot;
      ram_wdata = (op_r == OP_INSERT) ? data_r : '0;
    end
  end

  skht_ram #(
    .WIDTH (STORE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= 11'd1024;
      key_length    <= '0;
      first_pending <= 1'b1;
      overflow_flag <= 1'b0;
      clr_cnt       <= '0;
      div_cnt       <= '0;
      done          <= 1'b0;
    end else begin
      done <= cmd.commit || (cmd.prep && overflow_flag);
      if (cfg_we) begin
        slot_count <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.accept) begin
        first_pending <= 1'b0;
        if (key_length >= LW'(MAX_KEY_LEN)) begin
          overflow_flag <= 1'b1;
          key_length    <= LW'(MAX_KEY_LEN + 1);
        end else begin
          key_length <= key_length + LW'(1);
        end
      end
      if (cmd.prep) begin
        div_cnt <= '0;
        if (overflow_flag) begin
          first_pending <= 1'b1;
          key_length    <= '0;
          overflow_flag <= 1'b0;
        end
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 6'd1;
      end
      if (cmd.commit) begin
        first_pending <= 1'b1;
        key_length    <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= item.op;
      byte_r <= item.key_byte;
      last_r <= item.key_last;
      data_r <= item.data_in[STORE_W-1:0];
      if (first_pending) begin
        hash <= 64'(item.key_byte) << SEED_SHIFT;
      end
    end
    if (cmd.mul_lo) begin
      prod_lo <= mul_p;
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_p[31:0];
    end
    if (cmd.add) begin
      hash <= hash_sum;
    end
    if (cmd.prep) begin
      dividend <= hash_fix;
      divisor  <= eff;
      rem      <= '0;
      if (overflow_flag) begin
        result.entry_data   <= '0;
        result.present      <= 1'b0;
        result.slot_index   <= '0;
        result.key_too_long <= 1'b1;
      end
    end
    if (cmd.div_step) begin
      dividend <= {dividend[62:0], 1'b0};
      rem      <= rem_next;
    end
    if (cmd.commit) begin
      result.entry_data   <= 32'(ram_rdata);
      result.present      <= |ram_rdata;
      result.slot_index   <= 10'(rem);
      result.key_too_long <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/string_keyed_direct_hash_table.sv
// ----------------------------------------------------------------------------
// string_keyed_direct_hash_table: direct mapped table keyed by byte strings
// Streams a key one byte per beat, hashes it and applies get, exists,
// insert or remove to the one slot the key maps to.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the table to zero with busy high;
// configuration writes are taken during the sweep. A byte beat is taken
// when start is high and busy is low. A byte that does not end the key
// passes through one shared 32x20 constant multiplier, low half then high
// half, and an add into the hash. The last byte also takes a step to finish
// the hash, a one-bit-per-cycle remainder of the 64-bit hash by the slot
// count, and a read then a write of the slot RAM. A key longer than
// MAX_KEY_LEN ends at its last byte, after the add, with key_too_long set.
// Each key end yields one result beat, shown for exactly one cycle with done
// high; the receiver cannot stall it, and the next byte may be started in
// that same cycle. The user must write slot_count with cfg_we and cfg_wdata
// only while the block is idle; the block does not enforce it. 0 acts as 1
// and values above TABLE_DEPTH act as TABLE_DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module string_keyed_direct_hash_table
  import skht_pkg::*;
#(
  parameter int TABLE_DEPTH  = 1024,
  parameter int MAX_KEY_LEN  = 4096,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output result_t          result,
  output logic             done,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // sequencer: owns the state, issues at most one command per cycle
  skht_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // datapath: hash, remainder, slot RAM, result register
  skht_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_KEY_LEN  (MAX_KEY_LEN),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .done      (done)
  );

  // a result beat only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

  // an accepted byte always starts the multiply sequence
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted byte did not start work");

  // results are single cycle beats, never back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // present flag matches the reported slot contents
  a_present: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.present == (result.entry_data != 32'd0)))
    else $error("present flag disagrees with entry data");

endmodule

`default_nettype wire
